/* hw/rtl/psvg_pkg.sv */
// Shared types, field widths and constants of the polar shape vertex generator.
package psvg_pkg;

    localparam int CNT_W    = 7;
    localparam int RAD_W    = 11;
    localparam int START_W  = 15;
    localparam int SPAN_W   = 16;
    localparam int TD_W     = 8;
    localparam int OP_W     = 3;
    localparam int TOT_W    = 9;
    localparam int SC_W     = START_W + CNT_W;
    localparam int DENLO_W  = 1 + CNT_W + TD_W;
    localparam int IDX_W    = 6;
    localparam int ANG_W    = 32;
    localparam int XY_W     = 34;
    localparam int Z_W      = 33;
    localparam int NUM_W    = 25;
    localparam int CORDIC_STEPS = 24;
    localparam logic [TD_W-1:0]  TD_MIN   = 8'd32;
    localparam logic [XY_W-1:0]  GAIN_Q30 = 34'd652032874;

    typedef enum logic [OP_W-1:0] {
        OP_NGON    = 3'd0,
        OP_STAR    = 3'd1,
        OP_GEAR    = 3'd2,
        OP_ARC     = 3'd3,
        OP_WEDGE   = 3'd4,
        OP_ANNULUS = 3'd5
    } t_op;

    typedef struct packed {
        t_op                        op;
        logic [CNT_W-1:0]           cnt;
        logic [TOT_W-1:0]           total;
        logic [RAD_W-1:0]           r1x;
        logic [RAD_W-1:0]           r1y;
        logic [RAD_W-1:0]           r2x;
        logic [RAD_W-1:0]           r2y;
        logic [SC_W-1:0]            start_cnt;
        logic signed [SPAN_W-1:0]   span;
        logic [TD_W-1:0]            td;
        logic [DENLO_W-1:0]         den_lo;
    } t_cmd;

    // Arctangent of 2^-k as a fraction of a turn, scaled by 2^32.
    function automatic logic [ANG_W-1:0] atan_turn(input logic [4:0] k);
        logic [ANG_W-1:0] v;
        case (k)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* hw/rtl/psvg_front.sv */
// Request front end: takes a request word, clamps and classifies it, builds a command.
module psvg_front (
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [2:0]                  i_op,
    input  logic [6:0]                  i_count,
    input  logic [10:0]                 i_radius1_x,
    input  logic [10:0]                 i_radius1_y,
    input  logic [10:0]                 i_radius2_x,
    input  logic [10:0]                 i_radius2_y,
    input  logic [14:0]                 i_start_angle,
    input  logic signed [15:0]          i_span_angle,
    input  logic [7:0]                  i_tooth_divisor,
    input  logic                        i_full,
    output logic                        o_push,
    output psvg_pkg::t_cmd              o_cmd
);
    import psvg_pkg::*;

    logic [CNT_W-1:0] cnt;
    logic [TD_W-1:0]  td;
    logic [TOT_W-1:0] total;
    logic             op_ok;

    assign cnt = (i_count == '0) ? CNT_W'(1) : i_count;
    assign td  = (i_tooth_divisor < TD_MIN) ? TD_MIN : i_tooth_divisor;

    always_comb begin
        op_ok = 1'b1;
        total = TOT_W'(cnt);
        case (i_op)
            OP_NGON:    total = TOT_W'(cnt);
            OP_STAR:    total = TOT_W'({cnt, 1'b0});
            OP_GEAR:    total = TOT_W'({cnt, 2'b00});
            OP_ARC:     total = TOT_W'(cnt) + TOT_W'(1);
            OP_WEDGE:   total = TOT_W'(cnt) + TOT_W'(2);
            OP_ANNULUS: total = TOT_W'({cnt, 1'b0}) + TOT_W'(2);
            default:    op_ok = 1'b0;
        endcase
    end

    // Requests with an unused shape code produce no vertices and are dropped here.
    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full && op_ok;

    always_comb begin
        o_cmd.op        = t_op'(i_op);
        o_cmd.cnt       = cnt;
        o_cmd.total     = total;
        o_cmd.r1x       = i_radius1_x;
        o_cmd.r1y       = i_radius1_y;
        o_cmd.r2x       = i_radius2_x;
        o_cmd.r2y       = i_radius2_y;
        o_cmd.start_cnt = SC_W'(i_start_angle) * SC_W'(cnt);
        o_cmd.span      = i_span_angle;
        o_cmd.td        = td;
        o_cmd.den_lo    = DENLO_W'({cnt, 1'b0}) * DENLO_W'(td);
    end

endmodule

/* hw/rtl/psvg_queue.sv */
// Two-entry command queue between the front end and the vertex engine.
module psvg_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  psvg_pkg::t_cmd      i_cmd,
    input  logic                i_pop,
    output logic                o_full,
    output logic                o_empty,
    output psvg_pkg::t_cmd      o_cmd
);
    import psvg_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

/* hw/rtl/psvg_cordic.sv */
// Iterative rotation CORDIC giving sine and cosine of a binary angle in Q30.
module psvg_cordic (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_start,
    input  logic [psvg_pkg::ANG_W-1:0]              i_angle,
    output logic                                    o_done,
    output logic signed [psvg_pkg::XY_W-1:0]        o_sin,
    output logic signed [psvg_pkg::XY_W-1:0]        o_cos
);
    import psvg_pkg::*;

    logic signed [XY_W-1:0] r_x;
    logic signed [XY_W-1:0] r_y;
    logic signed [Z_W-1:0]  r_z;
    logic [1:0]             r_quad;
    logic [4:0]             r_k;
    logic                   r_busy;
    logic                   r_done;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic signed [Z_W-1:0]  dz;

    assign dx = r_y >>> r_k;
    assign dy = r_x >>> r_k;
    assign dz = $signed(Z_W'(atan_turn(r_k)));

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= $signed(GAIN_Q30);
            r_y    <= '0;
            r_z    <= $signed(Z_W'(i_angle[ANG_W-3:0]));
            r_quad <= i_angle[ANG_W-1:ANG_W-2];
        end else if (r_busy) begin
            if (r_z >= 0) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - dz;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + dz;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_k    <= '0;
            end else if (r_busy) begin
                if (r_k == 5'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_k <= r_k + 5'd1;
                end
            end
        end
    end

    // Fold the first-quadrant result back to the full turn.
    always_comb begin
        case (r_quad)
            2'd0: begin
                o_sin = r_y;
                o_cos = r_x;
            end
            2'd1: begin
                o_sin = r_x;
                o_cos = -r_y;
            end
            2'd2: begin
                o_sin = -r_y;
                o_cos = -r_x;
            end
            default: begin
                o_sin = -r_x;
                o_cos = r_y;
            end
        endcase
    end

    assign o_done = r_done;

endmodule

/* hw/rtl/psvg_back.sv */
// Vertex engine: walks the vertices of one command, finds each angle, rotates and scales.
module psvg_back #(
    parameter int MAX_VERTS       = 64,
    parameter int ANGLE_FRAC_BITS = 6,
    parameter int COORD_BITS      = 12
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  psvg_pkg::t_cmd                  i_cmd,
    input  logic                            i_empty,
    output logic                            o_pop,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic signed [COORD_BITS-1:0]    o_x,
    output logic signed [COORD_BITS-1:0]    o_y,
    output logic [5:0]                      o_vertex_index,
    output logic                            o_last
);
    import psvg_pkg::*;

    localparam int TURN  = 360 << ANGLE_FRAC_BITS;
    localparam int TW    = $clog2(TURN + 1);
    localparam int DW    = TW + CNT_W;
    localparam int KW    = $clog2(MAX_VERTS);
    localparam int NVW   = $clog2(MAX_VERTS + 1);
    localparam int MAG_W = NUM_W - 1;
    localparam int PW    = XY_W + RAD_W + 1;
    localparam int VW    = PW - 30;
    localparam int IT_W  = 6;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_NUM   = 10'b0000000010,
        S_MOD   = 10'b0000000100,
        S_FIX   = 10'b0000001000,
        S_DIV   = 10'b0000010000,
        S_CST   = 10'b0000100000,
        S_CWAIT = 10'b0001000000,
        S_MX    = 10'b0010000000,
        S_MY    = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    t_state                  r_state;
    t_cmd                    r_cmd;
    logic [DW-1:0]           r_den;
    logic [NVW-1:0]          r_n;
    logic [KW-1:0]           r_k;
    logic                    r_neg;
    logic [MAG_W-1:0]        r_mag;
    logic [DW-1:0]           r_rem;
    logic [ANG_W-1:0]        r_h;
    logic [ANG_W-1:0]        r_q;
    logic [IT_W-1:0]         r_it;
    logic                    r_second;
    logic signed [PW-1:0]    r_px;
    logic signed [PW-1:0]    r_py;
    logic                    r_ovalid;
    logic signed [COORD_BITS-1:0] r_ox;
    logic signed [COORD_BITS-1:0] r_oy;
    logic [5:0]              r_oidx;
    logic                    r_olast;

    logic [8:0]              k9;
    logic [8:0]              cnt9;
    logic [8:0]              arc_i;
    logic                    origin;
    logic                    second;
    logic signed [16:0]      mul_a;
    logic [8:0]              mul_b;
    logic signed [NUM_W-1:0] addend;
    logic signed [26:0]      prod;
    logic signed [NUM_W-1:0] num;
    logic                    step_bit;
    logic [DW:0]             rem2;
    logic                    ge;
    logic                    cord_start;
    logic                    cord_done;
    logic signed [XY_W-1:0]  sin_v;
    logic signed [XY_W-1:0]  cos_v;
    logic signed [XY_W-1:0]  trig;
    logic [RAD_W-1:0]        rad;
    logic signed [PW-1:0]    prod2;
    logic                    out_free;
    logic                    is_last;

    assign k9   = 9'(r_k);
    assign cnt9 = 9'(r_cmd.cnt);

    // Per-vertex numerator of the angle fraction, one multiply.
    always_comb begin
        origin = 1'b0;
        second = 1'b0;
        arc_i  = k9;
        mul_a  = 17'sd1;
        mul_b  = k9;
        addend = '0;
        if ((r_cmd.op == OP_ANNULUS) && (k9 > cnt9)) begin
            arc_i  = {cnt9[7:0], 1'b0} + 9'd1 - k9;
            second = 1'b1;
        end
        if ((r_cmd.op == OP_WEDGE) && (k9 == cnt9 + 9'd1)) begin
            origin = 1'b1;
        end
        case (r_cmd.op)
            OP_NGON: begin
                mul_b = k9;
            end
            OP_STAR: begin
                mul_b  = k9;
                second = k9[0];
            end
            OP_GEAR: begin
                mul_a  = $signed(17'(r_cmd.td));
                mul_b  = k9 >> 1;
                addend = k9[0] ? NUM_W'(32) : -NUM_W'(32);
                second = k9[1];
            end
            default: begin
                mul_a  = 17'(r_cmd.span);
                mul_b  = arc_i;
                addend = $signed(NUM_W'(r_cmd.start_cnt));
            end
        endcase
    end

    assign prod = mul_a * $signed({1'b0, mul_b});
    assign num  = prod[NUM_W-1:0] + addend;

    // One restoring step, shared by the modulo and the fraction division.
    assign step_bit = (r_state == S_MOD) ? r_mag[MAG_W-1] : r_h[ANG_W-1];
    assign rem2     = {r_rem, step_bit};
    assign ge       = (rem2 >= {1'b0, r_den});

    assign cord_start = (r_state == S_CST);

    psvg_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cord_start),
        .i_angle (r_q),
        .o_done  (cord_done),
        .o_sin   (sin_v),
        .o_cos   (cos_v)
    );

    always_comb begin
        if (r_state == S_MX) begin
            trig = sin_v;
            rad  = r_second ? r_cmd.r2x : r_cmd.r1x;
        end else begin
            trig = -cos_v;
            rad  = r_second ? r_cmd.r2y : r_cmd.r1y;
        end
    end

    assign prod2 = trig * $signed({1'b0, rad});

    function automatic logic signed [COORD_BITS-1:0] round_sat(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] t;
        logic signed [VW-1:0] v;
        logic signed [VW-1:0] hi;
        logic signed [VW-1:0] lo;
        t  = p + $signed(PW'(64'd1 << 29));
        v  = VW'(t >>> 30);
        hi = $signed(VW'((64'd1 << (COORD_BITS - 1)) - 64'd1));
        lo = -hi - VW'(1);
        if (v > hi) begin
            v = hi;
        end
        if (v < lo) begin
            v = lo;
        end
        return v[COORD_BITS-1:0];
    endfunction

    assign out_free = !r_ovalid || !i_stall;
    assign is_last  = (NVW'(r_k) == r_n - NVW'(1));
    assign o_pop    = (r_state == S_IDLE) && !i_empty;

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_cmd <= i_cmd;
                r_k   <= '0;
                if (10'(i_cmd.total) > 10'(MAX_VERTS)) begin
                    r_n <= NVW'(MAX_VERTS);
                end else begin
                    r_n <= NVW'(i_cmd.total);
                end
                case (i_cmd.op)
                    OP_NGON: r_den <= DW'(i_cmd.cnt);
                    OP_STAR: r_den <= DW'({i_cmd.cnt, 1'b0});
                    OP_GEAR: r_den <= DW'(i_cmd.den_lo);
                    default: r_den <= DW'(TURN) * DW'(i_cmd.cnt);
                endcase
            end
            S_NUM: begin
                r_second <= second;
                r_neg    <= num[NUM_W-1];
                r_mag    <= num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
                r_rem    <= '0;
                r_it     <= IT_W'(MAG_W);
                r_px     <= '0;
                r_py     <= '0;
            end
            S_MOD: begin
                r_rem <= ge ? DW'(rem2 - {1'b0, r_den}) : rem2[DW-1:0];
                r_mag <= r_mag << 1;
                r_it  <= r_it - IT_W'(1);
            end
            S_FIX: begin
                if (r_neg && (r_rem != '0)) begin
                    r_rem <= r_den - r_rem;
                end
                r_h  <= ANG_W'(r_den >> 1);
                r_it <= IT_W'(ANG_W);
            end
            S_DIV: begin
                r_rem <= ge ? DW'(rem2 - {1'b0, r_den}) : rem2[DW-1:0];
                r_h   <= r_h << 1;
                r_q   <= {r_q[ANG_W-2:0], ge};
                r_it  <= r_it - IT_W'(1);
            end
            S_MX: begin
                r_px <= prod2;
            end
            S_MY: begin
                r_py <= prod2;
            end
            S_OUT: begin
                if (out_free && !is_last) begin
                    r_k <= r_k + KW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && out_free) begin
            r_ox    <= round_sat(r_px);
            r_oy    <= round_sat(r_py);
            r_oidx  <= k9[5:0];
            r_olast <= is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if ((r_state == S_OUT) && out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_state <= S_NUM;
                    end
                end
                S_NUM: begin
                    r_state <= origin ? S_OUT : S_MOD;
                end
                S_MOD: begin
                    if (r_it == IT_W'(1)) begin
                        r_state <= S_FIX;
                    end
                end
                S_FIX: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_it == IT_W'(1)) begin
                        r_state <= S_CST;
                    end
                end
                S_CST: begin
                    r_state <= S_CWAIT;
                end
                S_CWAIT: begin
                    if (cord_done) begin
                        r_state <= S_MX;
                    end
                end
                S_MX: begin
                    r_state <= S_MY;
                end
                S_MY: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= is_last ? S_IDLE : S_NUM;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid        = r_ovalid;
    assign o_x            = r_ox;
    assign o_y            = r_oy;
    assign o_vertex_index = r_oidx;
    assign o_last         = r_olast;

endmodule

/* hw/rtl/polar_shape_vertex_generator.sv */
// Top level of the polar shape vertex generator.
//
// Usage: a request word (shape code, count, two radii, arc start and span,
// gear tooth divisor) enters on the input channel when i_valid is high and
// o_stall is low. The block answers with one word per outline vertex on the
// output channel (o_valid / i_stall), in outline order, numbered by
// o_vertex_index and with o_last on the final vertex of the request. A
// request with an unused shape code is taken and produces no words.
// The front end checks and clamps each request and places it in a two-entry
// command queue, so up to two requests can wait while the vertex engine works.
// The engine handles one vertex at a time: the angle numerator is formed with
// one multiply, reduced modulo a turn by a restoring unit, turned into a binary
// angle by a restoring divider that shares its step with that unit, rotated by
// a 24-step CORDIC and scaled by two multiplies on one shared multiplier. A
// wedge's closing origin vertex skips the angle, rotation and scaling steps.
// A vertex waits in the output register while the receiver stalls; the engine
// goes on to the next vertex and holds it until that word is taken, and the
// queue keeps taking requests while it has room.
// Reset is synchronous and active low; it empties the queue, idles the engine
// and drops any word not yet delivered.
module polar_shape_vertex_generator #(
    parameter int MAX_VERTS       = 64,
    parameter int ANGLE_FRAC_BITS = 6,
    parameter int COORD_BITS      = 12
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [2:0]                      i_op,
    input  logic [6:0]                      i_count,
    input  logic [10:0]                     i_radius1_x,
    input  logic [10:0]                     i_radius1_y,
    input  logic [10:0]                     i_radius2_x,
    input  logic [10:0]                     i_radius2_y,
    input  logic [14:0]                     i_start_angle,
    input  logic signed [15:0]              i_span_angle,
    input  logic [7:0]                      i_tooth_divisor,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic signed [COORD_BITS-1:0]    o_x,
    output logic signed [COORD_BITS-1:0]    o_y,
    output logic [5:0]                      o_vertex_index,
    output logic                            o_last
);
    import psvg_pkg::*;

    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic push;
    logic pop;
    logic full;
    logic empty;

    // Front end: classification of the incoming request word.
    psvg_front u_front (
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_op            (i_op),
        .i_count         (i_count),
        .i_radius1_x     (i_radius1_x),
        .i_radius1_y     (i_radius1_y),
        .i_radius2_x     (i_radius2_x),
        .i_radius2_y     (i_radius2_y),
        .i_start_angle   (i_start_angle),
        .i_span_angle    (i_span_angle),
        .i_tooth_divisor (i_tooth_divisor),
        .i_full          (full),
        .o_push          (push),
        .o_cmd           (front_cmd)
    );

    // Queue decoupling the front end from the engine.
    psvg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_cmd   (queue_cmd)
    );

    // Vertex engine with its own output register.
    psvg_back #(
        .MAX_VERTS       (MAX_VERTS),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .COORD_BITS      (COORD_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (queue_cmd),
        .i_empty        (empty),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_x            (o_x),
        .o_y            (o_y),
        .o_vertex_index (o_vertex_index),
        .o_last         (o_last)
    );

endmodule

/* tb/tb_polar_shape_vertex_generator.sv */
// Self-checking testbench for the polar shape vertex generator.
`timescale 1ns / 100ps

module tb_polar_shape_vertex_generator;
    import psvg_pkg::*;

    localparam int MAX_VERTS   = 64;
    localparam int FRAC_BITS   = 6;
    localparam int COORD_BITS  = 12;
    localparam int IDLE_LIMIT  = 40000;
    localparam int HOLD_CYCLES = 3000;
    localparam int TAIL_CYCLES = 300;

    // One shape request as offered on the input channel.
    typedef struct packed {
        logic [2:0]          op;
        logic [6:0]          cnt;
        logic [10:0]         r1x;
        logic [10:0]         r1y;
        logic [10:0]         r2x;
        logic [10:0]         r2y;
        logic [14:0]         start;
        logic signed [15:0]  span;
        logic [7:0]          td;
    } t_request;

    // One outline vertex as seen on the output channel.
    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic [5:0]                   idx;
        logic                         last;
    } t_vertex;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_stall;
    logic [2:0]                   i_op;
    logic [6:0]                   i_count;
    logic [10:0]                  i_radius1_x;
    logic [10:0]                  i_radius1_y;
    logic [10:0]                  i_radius2_x;
    logic [10:0]                  i_radius2_y;
    logic [14:0]                  i_start_angle;
    logic signed [15:0]           i_span_angle;
    logic [7:0]                   i_tooth_divisor;
    logic                         o_valid;
    logic                         i_stall;
    logic signed [COORD_BITS-1:0] o_x;
    logic signed [COORD_BITS-1:0] o_y;
    logic [5:0]                   o_vertex_index;
    logic                         o_last;

    polar_shape_vertex_generator #(
        .MAX_VERTS       (MAX_VERTS),
        .ANGLE_FRAC_BITS (FRAC_BITS),
        .COORD_BITS      (COORD_BITS)
    ) dut (.*);

    t_request pending_requests[$];
    t_vertex  expected_vertices[$];
    int       mismatch_count;
    int       idle_cycles;
    bit       stimulus_done;
    bit       long_hold;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Floor shift right of a signed 64-bit value.
    function automatic longint shift_floor(input longint v, input int k);
        return v >>> k;
    endfunction

    // Exact rational fraction of a turn turned into a 32-bit binary angle.
    function automatic logic [31:0] turn_fraction(input longint num, input longint den);
        longint m;
        logic [63:0] wide;
        m = num % den;
        if (m < 0) m += den;
        wide = ((64'(m) << 32) + 64'(den / 2)) / 64'(den);
        return wide[31:0];
    endfunction

    // Rotation-mode CORDIC on the angle within its quadrant, then the quadrant
    // is folded back in to give sine and cosine in Q30.
    task automatic rotate_angle(input logic [31:0] a, output longint s, output longint c);
        longint x, y, z, dx, dy;
        x = 64'(GAIN_Q30);
        y = 0;
        z = longint'(a[29:0]);
        for (int k = 0; k < CORDIC_STEPS; k++) begin
            dx = shift_floor(y, k);
            dy = shift_floor(x, k);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(atan_turn(5'(k)));
            end else begin
                x += dx; y -= dy; z += longint'(atan_turn(5'(k)));
            end
        end
        case (a[31:30])
            2'd0: begin s = y;  c = x;  end
            2'd1: begin s = x;  c = -y; end
            2'd2: begin s = -y; c = -x; end
            default: begin s = -x; c = y; end
        endcase
    endtask

    // Scale a Q30 trig value by a radius, round half up and saturate.
    function automatic logic signed [COORD_BITS-1:0] scale_coord(input longint trig,
                                                                 input longint r);
        longint v;
        longint hi;
        hi = (longint'(1) << (COORD_BITS - 1)) - 1;
        v = shift_floor(trig * r + (longint'(1) << 29), 30);
        if (v > hi) v = hi;
        if (v < -hi - 1) v = -hi - 1;
        return v[COORD_BITS-1:0];
    endfunction

    // Works out the whole outline of one request and queues its vertices.
    task automatic predict_outline(input t_request rq);
        longint cnt, td, total, n, i, sub, num, s, c, rx, ry, turn;
        logic [31:0] ang;
        bit second, origin;
        t_vertex v;
        cnt  = rq.cnt == 0 ? 1 : rq.cnt;
        td   = rq.td < TD_MIN ? TD_MIN : rq.td;
        turn = longint'(360) << FRAC_BITS;
        case (rq.op)
            OP_NGON:    total = cnt;
            OP_STAR:    total = 2 * cnt;
            OP_GEAR:    total = 4 * cnt;
            OP_ARC:     total = cnt + 1;
            OP_WEDGE:   total = cnt + 2;
            OP_ANNULUS: total = 2 * cnt + 2;
            default:    total = 0;
        endcase
        n = total > MAX_VERTS ? MAX_VERTS : total;
        for (longint k = 0; k < n; k++) begin
            second = 1'b0;
            origin = 1'b0;
            case (rq.op)
                OP_NGON: ang = turn_fraction(k, cnt);
                OP_STAR: begin
                    ang = turn_fraction(k, 2 * cnt);
                    second = k[0];
                end
                OP_GEAR: begin
                    i   = k >> 2;
                    sub = k & 3;
                    num = (2 * i + (sub >> 1)) * td + ((sub & 1) ? TD_MIN : -longint'(TD_MIN));
                    ang = turn_fraction(num, 2 * cnt * td);
                    second = sub >= 2;
                end
                default: begin
                    i = k;
                    if (rq.op == OP_WEDGE && k == cnt + 1) origin = 1'b1;
                    else if (rq.op == OP_ANNULUS && k > cnt) begin
                        i = 2 * cnt + 1 - k;
                        second = 1'b1;
                    end
                    ang = turn_fraction(longint'(rq.start) * cnt + longint'(rq.span) * i,
                                        turn * cnt);
                end
            endcase
            if (origin) begin
                v.x = '0;
                v.y = '0;
            end else begin
                rotate_angle(ang, s, c);
                rx = second ? rq.r2x : rq.r1x;
                ry = second ? rq.r2y : rq.r1y;
                v.x = scale_coord(s, rx);
                v.y = scale_coord(-c, ry);
            end
            v.idx  = k[5:0];
            v.last = (k == n - 1);
            expected_vertices.push_back(v);
        end
    endtask

    function automatic t_request random_request();
        t_request rq;
        rq.op    = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                                : 3'($urandom_range(0, 5));
        // Mostly small shapes keep the run short; a few reach the cut-off.
        rq.cnt   = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(0, 8));
        rq.r1x   = 11'($urandom);
        rq.r1y   = $urandom_range(0, 1) ? rq.r1x : 11'($urandom);
        rq.r2x   = 11'($urandom);
        rq.r2y   = $urandom_range(0, 1) ? rq.r2x : 11'($urandom);
        rq.start = 15'($urandom);
        rq.span  = 16'($urandom);
        rq.td    = 8'($urandom);
        return rq;
    endfunction

    function automatic t_request make_request(input logic [2:0] op, input logic [6:0] cnt,
                                              input logic [10:0] r1, input logic [10:0] r2,
                                              input logic [14:0] start,
                                              input logic signed [15:0] span,
                                              input logic [7:0] td);
        t_request rq;
        rq = '{op, cnt, r1, r1, r2, r2, start, span, td};
        return rq;
    endfunction

    initial begin
        // Directed words: every shape, field extremes and the special cases.
        pending_requests.push_back(make_request(OP_NGON, 7'd1, 11'd2047, 11'd0, 15'd0, 16'sd0, 8'd0));
        pending_requests.push_back(make_request(OP_NGON, 7'd0, 11'd100, 11'd0, 15'd0, 16'sd0, 8'd0));
        pending_requests.push_back(make_request(OP_NGON, 7'd6, 11'd2047, 11'd0, 15'd0, 16'sd0, 8'd0));
        pending_requests.push_back(make_request(OP_NGON, 7'd127, 11'd1500, 11'd0, 15'd0, 16'sd0, 8'd0));
        pending_requests.push_back(make_request(OP_STAR, 7'd5, 11'd2047, 11'd0, 15'd0, 16'sd0, 8'd0));
        pending_requests.push_back(make_request(OP_STAR, 7'd40, 11'd300, 11'd2047, 15'd0, 16'sd0, 8'd0));
        pending_requests.push_back(make_request(OP_GEAR, 7'd3, 11'd500, 11'd600, 15'd0, 16'sd0, 8'd0));
        pending_requests.push_back(make_request(OP_GEAR, 7'd4, 11'd500, 11'd600, 15'd0, 16'sd0, 8'd31));
        pending_requests.push_back(make_request(OP_GEAR, 7'd2, 11'd2047, 11'd1, 15'd0, 16'sd0, 8'd255));
        pending_requests.push_back(make_request(OP_GEAR, 7'd20, 11'd800, 11'd900, 15'd0, 16'sd0, 8'd48));
        pending_requests.push_back(make_request(OP_ARC, 7'd4, 11'd700, 11'd0, 15'd0, 16'sd23040, 8'd0));
        pending_requests.push_back(make_request(OP_ARC, 7'd3, 11'd700, 11'd0, 15'd23039, -16'sd23040, 8'd0));
        pending_requests.push_back(make_request(OP_ARC, 7'd2, 11'd2047, 11'd0, 15'd32767, 16'sd32767, 8'd0));
        pending_requests.push_back(make_request(OP_ARC, 7'd1, 11'd1, 11'd0, 15'd100, -16'sd32768, 8'd0));
        pending_requests.push_back(make_request(OP_WEDGE, 7'd3, 11'd900, 11'd0, 15'd5760, 16'sd5760, 8'd0));
        pending_requests.push_back(make_request(OP_WEDGE, 7'd70, 11'd900, 11'd0, 15'd0, 16'sd11520, 8'd0));
        pending_requests.push_back(make_request(OP_ANNULUS, 7'd3, 11'd1000, 11'd400, 15'd0, 16'sd11520, 8'd0));
        pending_requests.push_back(make_request(OP_ANNULUS, 7'd40, 11'd1000, 11'd400, 15'd0, -16'sd8000, 8'd0));
        pending_requests.push_back(make_request(3'd6, 7'd5, 11'd100, 11'd100, 15'd0, 16'sd0, 8'd0));
        pending_requests.push_back(make_request(3'd7, 7'd5, 11'd100, 11'd100, 15'd0, 16'sd0, 8'd0));
        pending_requests.push_back('{OP_NGON, 7'd4, 11'd2047, 11'd0, 11'd0, 11'd2047,
                                     15'd0, 16'sd0, 8'd0});
        for (int k = 0; k < 90; k++) pending_requests.push_back(random_request());
    end

    // Driver: bursts of words with random gaps; payload held while stalled.
    int burst_left;
    int gap_left;
    t_request cur_request;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else if (i_valid && o_stall) begin
            // Word still waiting: keep everything as it is.
        end else begin
            if (i_valid) begin
                predict_outline(cur_request);
            end
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_valid  <= 1'b0;
            end else if (pending_requests.size() > 0 && (burst_left > 0 || !i_valid)) begin
                cur_request = pending_requests.pop_front();
                i_valid         <= 1'b1;
                i_op            <= cur_request.op;
                i_count         <= cur_request.cnt;
                i_radius1_x     <= cur_request.r1x;
                i_radius1_y     <= cur_request.r1y;
                i_radius2_x     <= cur_request.r2x;
                i_radius2_y     <= cur_request.r2y;
                i_start_angle   <= cur_request.start;
                i_span_angle    <= cur_request.span;
                i_tooth_divisor <= cur_request.td;
                if (burst_left > 0) burst_left <= burst_left - 1;
                else burst_left <= $urandom_range(0, 5);
            end else begin
                i_valid  <= 1'b0;
                gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 200);
                if (pending_requests.size() == 0 && i_valid) stimulus_done <= 1'b1;
                else if (pending_requests.size() == 0) stimulus_done <= 1'b1;
            end
        end
    end

    // Receiver stall pattern, with one long hold-off early in the run.
    int stall_phase;
    int hold_count;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall     <= 1'b0;
            stall_phase <= 0;
            hold_count  <= HOLD_CYCLES;
            long_hold   <= 1'b0;
        end else if (!long_hold && hold_count > 0 && pending_requests.size() < 95) begin
            long_hold <= 1'b1;
            i_stall   <= 1'b1;
        end else if (long_hold && hold_count > 0) begin
            hold_count <= hold_count - 1;
            i_stall    <= 1'b1;
        end else begin
            stall_phase <= stall_phase + 1;
            // Busy stretch with a fixed stall pattern, then a quiet one.
            if (stall_phase[9]) i_stall <= 1'b0;
            else i_stall <= (stall_phase % 7 == 2) || (stall_phase % 13 < 3);
        end
    end

    // Monitor: compares each taken vertex with the oldest prediction.
    t_vertex got;
    t_vertex want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_x, o_y, o_vertex_index, o_last};
            if (expected_vertices.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected vertex x=%0d y=%0d index=%0d last=%0d",
                             got.x, got.y, got.idx, got.last);
            end else begin
                want = expected_vertices.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("vertex mismatch: expected x=%0d y=%0d index=%0d last=%0d, got x=%0d y=%0d index=%0d last=%0d",
                                 want.x, want.y, want.idx, want.last,
                                 got.x, got.y, got.idx, got.last);
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither channel moves a word.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    initial begin
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_stall         = 1'b0;
        i_op            = '0;
        i_count         = '0;
        i_radius1_x     = '0;
        i_radius1_y     = '0;
        i_radius2_x     = '0;
        i_radius2_y     = '0;
        i_start_angle   = '0;
        i_span_angle    = '0;
        i_tooth_divisor = '0;
        mismatch_count  = 0;
        idle_cycles     = 0;
        stimulus_done   = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (!(stimulus_done && expected_vertices.size() == 0) &&
               idle_cycles < IDLE_LIMIT)
            @(posedge i_clk);
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_polar_shape_vertex_generator: done, errors");
        end else begin
            // Let any stray vertex show itself before judging the run.
            repeat (TAIL_CYCLES) @(posedge i_clk);
            if (mismatch_count == 0 && expected_vertices.size() == 0)
                $display("tb_polar_shape_vertex_generator: done, clean");
            else
                $display("tb_polar_shape_vertex_generator: done, errors");
        end
        $finish;
    end

endmodule

/* polar_shape_vertex_generator.f */
hw/rtl/psvg_pkg.sv
hw/rtl/psvg_front.sv
hw/rtl/psvg_queue.sv
hw/rtl/psvg_cordic.sv
hw/rtl/psvg_back.sv
hw/rtl/polar_shape_vertex_generator.sv
tb/tb_polar_shape_vertex_generator.sv
